>>> design/bgd_pkg.sv
// shared types, constants and helpers of the button gesture detector
// no dependencies; used by every other design file through scoped names
package bgd_pkg;

    // timestamp arithmetic width, wrapping differences are taken at this width
    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int WIN_BITS  = 16;
    localparam int CODE_BITS = 3;

    // register file
    localparam int APB_DATA_BITS = 32;
    localparam int REG_COUNT     = 4;
    localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [WIN_BITS-1:0]  win_t;
    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t REG_ACTIVE_LOW    = reg_idx_t'(0);
    localparam reg_idx_t REG_DOUBLE_WINDOW = reg_idx_t'(1);
    localparam reg_idx_t REG_HOLD_TIME     = reg_idx_t'(2);
    localparam reg_idx_t REG_DOUBLE_ENABLE = reg_idx_t'(3);

    localparam win_t DOUBLE_WINDOW_RST = win_t'(700);
    localparam win_t HOLD_TIME_RST     = win_t'(5000);

    // reported gesture codes
    localparam code_t CODE_IDLE      = code_t'(0);
    localparam code_t CODE_DOWN      = code_t'(1);
    localparam code_t CODE_UP        = code_t'(2);
    localparam code_t CODE_DBL_DOWN  = code_t'(3);
    localparam code_t CODE_DBL_UP    = code_t'(4);
    localparam code_t CODE_HOLD_DOWN = code_t'(5);
    localparam code_t CODE_HOLD_UP   = code_t'(6);

    typedef enum logic [6:0] {
        G_IDLE      = 7'b000_0001,
        G_DOWN      = 7'b000_0010,
        G_UP        = 7'b000_0100,
        G_DBL_DOWN  = 7'b000_1000,
        G_DBL_UP    = 7'b001_0000,
        G_HOLD_DOWN = 7'b010_0000,
        G_HOLD_UP   = 7'b100_0000
    } gesture_t;

    typedef struct packed {
        logic active_low;
        win_t double_window;
        win_t hold_time;
        logic double_enable;
    } cfg_t;

    typedef struct packed {
        code_t gesture;
        logic  changed;
    } res_t;

    // timestamp port reduced or extended to the arithmetic width
    function automatic time_t to_time(input logic [NOW_BITS-1:0] now);
        return TIME_BITS'(now);
    endfunction

    function automatic code_t gesture_code(input gesture_t g);
        code_t c;
        c = CODE_IDLE;
        unique case (g)
            G_IDLE:      c = CODE_IDLE;
            G_DOWN:      c = CODE_DOWN;
            G_UP:        c = CODE_UP;
            G_DBL_DOWN:  c = CODE_DBL_DOWN;
            G_DBL_UP:    c = CODE_DBL_UP;
            G_HOLD_DOWN: c = CODE_HOLD_DOWN;
            G_HOLD_UP:   c = CODE_HOLD_UP;
            default:     c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

>>> design/bgd_cfg.sv
// apb register file: polarity, double press window, hold time, double enable
// depends on bgd_pkg
module bgd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bgd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bgd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bgd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output bgd_pkg::cfg_t                      cfg
);

    bgd_pkg::cfg_t     cfg_reg;
    bgd_pkg::cfg_t     cfg_next;
    bgd_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = paddr[bgd_pkg::APB_ADDR_BITS-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                bgd_pkg::REG_ACTIVE_LOW:    cfg_next.active_low    = pwdata[0];
                bgd_pkg::REG_DOUBLE_WINDOW: cfg_next.double_window =
                                                pwdata[bgd_pkg::WIN_BITS-1:0];
                bgd_pkg::REG_HOLD_TIME:     cfg_next.hold_time     =
                                                pwdata[bgd_pkg::WIN_BITS-1:0];
                bgd_pkg::REG_DOUBLE_ENABLE: cfg_next.double_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            bgd_pkg::REG_ACTIVE_LOW:    prdata = bgd_pkg::APB_DATA_BITS'(cfg_reg.active_low);
            bgd_pkg::REG_DOUBLE_WINDOW: prdata = bgd_pkg::APB_DATA_BITS'(cfg_reg.double_window);
            bgd_pkg::REG_HOLD_TIME:     prdata = bgd_pkg::APB_DATA_BITS'(cfg_reg.hold_time);
            bgd_pkg::REG_DOUBLE_ENABLE: prdata = bgd_pkg::APB_DATA_BITS'(cfg_reg.double_enable);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_low    <= 1'b0;
            cfg_reg.double_window <= bgd_pkg::DOUBLE_WINDOW_RST;
            cfg_reg.hold_time     <= bgd_pkg::HOLD_TIME_RST;
            cfg_reg.double_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // a write to the hold time register lands exactly as written
    a_hold_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && idx == bgd_pkg::REG_HOLD_TIME
        |=> cfg_reg.hold_time == $past(pwdata[bgd_pkg::WIN_BITS-1:0]))
        else $error("hold time register not updated by write");

    // without a write the configuration stays put
    a_cfg_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

    // double window follows its own register only
    a_window_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && idx != bgd_pkg::REG_DOUBLE_WINDOW |=> $stable(cfg_reg.double_window))
        else $error("double window changed by another register write");

endmodule

>>> design/bgd_fsm.sv
// gesture state machine with press start timestamp; advances one poll per step
// depends on bgd_pkg
module bgd_fsm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic                           level,
    input  logic [bgd_pkg::NOW_BITS-1:0]   now_ms,
    input  bgd_pkg::cfg_t                  cfg,
    output bgd_pkg::res_t                  res
);

    bgd_pkg::gesture_t state_reg;
    bgd_pkg::gesture_t state_next;
    bgd_pkg::time_t    press_time_reg;
    bgd_pkg::time_t    press_time_next;
    bgd_pkg::time_t    now_t;
    bgd_pkg::time_t    elapsed;
    logic              pressed;
    logic              in_window;
    logic              past_hold;

    assign now_t     = bgd_pkg::to_time(now_ms);
    assign pressed   = cfg.active_low ? ~level : level;
    assign elapsed   = now_t - press_time_reg;
    assign in_window = elapsed < bgd_pkg::TIME_BITS'(cfg.double_window);
    assign past_hold = elapsed > bgd_pkg::TIME_BITS'(cfg.hold_time);

    always_comb begin
        state_next      = state_reg;
        press_time_next = press_time_reg;
        if (pressed) begin
            unique case (state_reg)
                bgd_pkg::G_IDLE: begin
                    state_next      = (in_window && cfg.double_enable) ?
                                      bgd_pkg::G_DBL_DOWN : bgd_pkg::G_DOWN;
                    press_time_next = now_t;
                end
                bgd_pkg::G_DOWN: begin
                    if (past_hold) begin
                        state_next = bgd_pkg::G_HOLD_DOWN;
                    end
                end
                default: state_next = state_reg;
            endcase
        end else begin
            unique case (state_reg)
                bgd_pkg::G_DOWN:      state_next = bgd_pkg::G_UP;
                bgd_pkg::G_HOLD_DOWN: state_next = bgd_pkg::G_HOLD_UP;
                bgd_pkg::G_DBL_DOWN:  state_next = bgd_pkg::G_DBL_UP;
                default:              state_next = bgd_pkg::G_IDLE;
            endcase
        end
    end

    assign res.gesture = bgd_pkg::gesture_code(state_next);
    assign res.changed = (state_next != state_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bgd_pkg::G_IDLE;
            press_time_reg <= '0;
        end else if (step) begin
            state_reg      <= state_next;
            press_time_reg <= press_time_next;
        end
    end

    // a release always lands in a released or idle state
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !pressed |=> state_reg == bgd_pkg::G_UP || state_reg == bgd_pkg::G_HOLD_UP ||
                             state_reg == bgd_pkg::G_DBL_UP || state_reg == bgd_pkg::G_IDLE)
        else $error("release left the machine in a pressed state");

    // a new press captures its timestamp
    a_press_time: assert property (@(posedge aclk) disable iff (!aresetn)
        step && pressed && state_reg == bgd_pkg::G_IDLE
        |=> press_time_reg == bgd_pkg::to_time($past(now_ms)))
        else $error("press start time not captured");

    // hold is reached only from a plain press
    a_hold_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        step && state_next == bgd_pkg::G_HOLD_DOWN
        |-> state_reg == bgd_pkg::G_DOWN || state_reg == bgd_pkg::G_HOLD_DOWN)
        else $error("hold entered from a state other than down");

    // no poll, no state change
    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(state_reg) && $stable(press_time_reg))
        else $error("state moved without a poll");

endmodule

>>> design/button_gesture_detector.sv
// button gesture detector, top level: request registers, gesture machine, result register
// path: an accepted request is held in the request register, and its result is captured in
//   the result register on the same edge that updates the gesture state
// throughput: one request per cycle while the result channel is not stalled; the gesture state feeds back
// reset: aresetn synchronous active low; clears handshake state, gesture state to idle,
//   press start time to zero and configuration to its defaults
module button_gesture_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_level,
    input  logic [bgd_pkg::NOW_BITS-1:0]       s_now_ms,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bgd_pkg::CODE_BITS-1:0]      m_gesture_state,
    output logic                               m_changed,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bgd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bgd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bgd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    bgd_pkg::cfg_t cfg;
    bgd_pkg::res_t res;

    // request register
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic                         in_level_reg;
    logic [bgd_pkg::NOW_BITS-1:0] in_now_reg;

    // result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    bgd_pkg::res_t                out_res_reg;

    logic s_take;
    logic advance;
    logic step;

    // the result register can take a new value when empty or being drained
    assign advance = ~out_valid_reg | m_ready;
    // a held request moves into the gesture machine and result register together
    assign step    = in_valid_reg & advance;
    // the request register frees up in the same cycle its contents move on
    assign s_ready = ~in_valid_reg | advance;
    assign s_take  = s_valid & s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_level_reg <= s_level;
            in_now_reg   <= s_now_ms;
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

    bgd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state update happens on the same edge the result is captured
    bgd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .level   (in_level_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_valid         = out_valid_reg;
    assign m_gesture_state = out_res_reg.gesture;
    assign m_changed       = out_res_reg.changed;

    // a request that moves on always shows up as a result
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("processed request produced no result");

    // a result that is not taken keeps the request register from draining
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid && !m_ready |=> in_valid_reg)
        else $error("request dropped while result stalled");

    // the request stage never accepts while full and blocked
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> !s_ready)
        else $error("request accepted into a full stage");

endmodule
